// File: rtl/core/adpcm4_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adpcm4_pkg
// Shared types and constants for the leaky 4-bit ADPCM decoder.
// ----------------------------------------------------------------------------
package adpcm4_pkg;

  // Step size limits and reload value
  localparam logic [14:0] StepMin = 15'h007f;
  localparam logic [14:0] StepMax = 15'h6000;

  // Saturation limits of the 16-bit sample
  localparam logic signed [15:0] SampleMax = 16'sh7fff;
  localparam logic signed [15:0] SampleMin = 16'sh8000;

  // One input word: a byte with two codes plus stream flags
  typedef struct packed {
    logic [7:0] code_byte;
    logic       stream_start;
    logic       stream_end;
  } in_item_t;

  // One output word: a decoded sample plus position flags
  typedef struct packed {
    logic signed [15:0] pcm_sample;
    logic               second_of_byte;
    logic               end_of_stream;
  } out_item_t;

  // One nibble command handed from the front to the back
  typedef struct packed {
    logic [3:0] code;
    logic       start;
    logic       second;
    logic       last;
  } nib_cmd_t;

  // Step rescale factor, applied as (step * factor) >> 8
  function automatic logic [9:0] step_scale(input logic [2:0] idx);
    logic [9:0] f;
    case (idx)
      3'd4:    f = 10'h133;
      3'd5:    f = 10'h199;
      3'd6:    f = 10'h200;
      3'd7:    f = 10'h266;
      default: f = 10'h0e6;
    endcase
    return f;
  endfunction

endpackage

// File: rtl/core/adpcm4_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adpcm4_front
// Accepts code bytes and splits each into two nibble commands, low first.
// ----------------------------------------------------------------------------
module adpcm4_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  adpcm4_pkg::in_item_t in_item_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output adpcm4_pkg::nib_cmd_t cmd_o,
  output logic                 cmd_valid_o,
  input  logic                 cmd_stall_i
);
  import adpcm4_pkg::*;

  in_item_t hold_q;
  logic     full_q, full_d;
  logic     phase_q, phase_d;
  logic     push;
  logic     accept;

  // Push a nibble whenever a byte is held and the queue has room
  assign push        = full_q && !cmd_stall_i;
  assign in_stall_o  = full_q && !(phase_q && push);
  assign accept      = in_valid_i && !in_stall_o;
  assign cmd_valid_o = full_q;

  // Build the command for the current nibble
  always_comb begin
    cmd_o.code   = phase_q ? hold_q.code_byte[7:4] : hold_q.code_byte[3:0];
    cmd_o.start  = !phase_q && hold_q.stream_start;
    cmd_o.second = phase_q;
    cmd_o.last   = phase_q && hold_q.stream_end;
  end

  // Advance phase and occupancy
  always_comb begin
    full_d  = full_q;
    phase_d = phase_q;
    if (push) begin
      phase_d = !phase_q;
      if (phase_q) begin
        full_d = 1'b0;
      end
    end
    if (accept) begin
      full_d  = 1'b1;
      phase_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q  <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      full_q  <= full_d;
      phase_q <= phase_d;
    end
  end

  // Hold the accepted byte
  always_ff @(posedge clk_i) begin
    if (accept) begin
      hold_q <= in_item_i;
    end
  end

endmodule

// File: rtl/core/adpcm4_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adpcm4_fifo
// Short queue of nibble commands between the front and the back.
// ----------------------------------------------------------------------------
module adpcm4_fifo #(
  parameter int Depth = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  adpcm4_pkg::nib_cmd_t wr_cmd_i,
  input  logic                 wr_valid_i,
  output logic                 wr_stall_o,
  output adpcm4_pkg::nib_cmd_t rd_cmd_o,
  output logic                 rd_valid_o,
  input  logic                 rd_pop_i
);
  import adpcm4_pkg::*;

  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(Depth);

  nib_cmd_t         mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             wr_en, rd_en;

  assign wr_stall_o = (cnt_q == FullCnt);
  assign rd_valid_o = (cnt_q != '0);
  assign wr_en      = wr_valid_i && !wr_stall_o;
  assign rd_en      = rd_pop_i && rd_valid_o;
  assign rd_cmd_o   = mem_q[rd_ptr_q];

  // Store incoming commands
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + AddrW'(1);
      end
      if (rd_en) begin
        rd_ptr_q <= (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + AddrW'(1);
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// File: rtl/core/adpcm4_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adpcm4_back
// Decodes one nibble at a time on a shared multiplier and drives the output.
// ----------------------------------------------------------------------------
module adpcm4_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  adpcm4_pkg::nib_cmd_t  cmd_i,
  input  logic                  cmd_valid_i,
  output logic                  cmd_pop_o,
  output adpcm4_pkg::out_item_t out_item_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i
);
  import adpcm4_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIFF = 4'b0010,
    S_STEP = 4'b0100,
    S_DONE = 4'b1000
  } back_state_e;

  back_state_e        state_q, state_d;
  nib_cmd_t           cmd_q;
  logic [14:0]        step_q;
  logic signed [15:0] pred_q;
  logic [24:0]        prod_q;
  logic signed [15:0] sum_q;
  out_item_t          out_q;
  logic               out_valid_q;

  logic [9:0]         mul_b;
  logic [24:0]        mul_p;
  logic [15:0]        diff_mag;
  logic signed [17:0] pred_ext, sum_w;
  logic signed [15:0] sum_sat;
  logic [16:0]        step_raw;
  logic [14:0]        step_next;
  logic signed [24:0] sum_ext, decay_x, decay_y;
  logic signed [15:0] pred_next;
  logic               out_free;
  logic               finish;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign finish      = (state_q == S_DONE) && out_free;
  assign cmd_pop_o   = (state_q == S_IDLE) && cmd_valid_i;
  assign out_item_o  = out_q;
  assign out_valid_o = out_valid_q;

  // Shared multiplier: odd magnitude first, then the rescale factor
  assign mul_b = (state_q == S_DIFF) ? {6'b0, cmd_q.code[2:0], 1'b1}
                                     : step_scale(cmd_q.code[2:0]);
  assign mul_p = {10'b0, step_q} * {15'b0, mul_b};

  // Add the difference, divided by 8 toward zero, and saturate
  always_comb begin
    diff_mag = prod_q[18:3];
    pred_ext = {{2{pred_q[15]}}, pred_q};
    if (cmd_q.code[3]) begin
      sum_w = pred_ext - $signed({2'b0, diff_mag});
    end else begin
      sum_w = pred_ext + $signed({2'b0, diff_mag});
    end
    if (sum_w > 18'sd32767) begin
      sum_sat = SampleMax;
    end else if (sum_w < -18'sd32768) begin
      sum_sat = SampleMin;
    end else begin
      sum_sat = sum_w[15:0];
    end
  end

  // Clamp the rescaled step size
  always_comb begin
    step_raw = prod_q[24:8];
    if (step_raw < {2'b0, StepMin}) begin
      step_next = StepMin;
    end else if (step_raw > {2'b0, StepMax}) begin
      step_next = StepMax;
    end else begin
      step_next = step_raw[14:0];
    end
  end

  // Decay by 254/256, truncating toward zero
  always_comb begin
    sum_ext = {{9{sum_q[15]}}, sum_q};
    decay_x = (sum_ext <<< 8) - (sum_ext <<< 1);
    decay_y = decay_x[24] ? (decay_x + 25'sd255) : decay_x;
    pred_next = decay_y[23:8];
  end

  // Sequence one nibble
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          state_d = S_DIFF;
        end
      end
      S_DIFF:  state_d = S_STEP;
      S_STEP:  state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control and predictor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= StepMin;
      pred_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_pop_o && cmd_i.start) begin
        step_q <= StepMin;
        pred_q <= '0;
      end
      if (finish) begin
        step_q <= step_next;
        pred_q <= pred_next;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    if (state_q == S_DIFF || state_q == S_STEP) begin
      prod_q <= mul_p;
    end
    if (state_q == S_STEP) begin
      sum_q <= sum_sat;
    end
    if (finish) begin
      out_q.pcm_sample     <= sum_q;
      out_q.second_of_byte <= cmd_q.second;
      out_q.end_of_stream  <= cmd_q.last;
    end
  end

  // Step size stays inside its clamp range
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q >= StepMin) && (step_q <= StepMax))
    else $error("step size out of range");

  // A new output word is written only when a nibble finishes
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("output raised outside finish");

  // Commands are taken only while idle
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> (state_q == S_DIFF))
    else $error("pop without starting a nibble");

endmodule

// File: rtl/core/adpcm_4bit_decoder_leaky_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adpcm_4bit_decoder_leaky_top
// Leaky 4-bit ADPCM decoder: one code byte in, two 16-bit samples out.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Word
//  --------+-----------+----------------------+-------------------------------
//  in      | input     | in_valid_i/in_stall_o  | in_item_t (byte, start, end)
//  out     | output    | out_valid_o/out_stall_i| out_item_t (sample, flags)
//
//  In the back end each nibble makes two passes through the shared 15x10
//  multiplier, then saturate/decay; it takes no new nibble until then.
//  The front holds one byte and the nibble queue buffers QueueDepth commands.
//  Reset clears the predictor to 0 and the step size to 0x7f.
//  A stalled output holds the decoder in its finish step; the queue then fills
//  and the input stalls.
// ----------------------------------------------------------------------------
module adpcm_4bit_decoder_leaky_top #(
  parameter int QueueDepth = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  adpcm4_pkg::in_item_t  in_item_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output adpcm4_pkg::out_item_t out_item_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i
);
  import adpcm4_pkg::*;

  nib_cmd_t front_cmd, back_cmd;
  logic     front_valid, fifo_stall;
  logic     back_valid, back_pop;

  // Split bytes into nibble commands
  adpcm4_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_o       (front_cmd),
    .cmd_valid_o (front_valid),
    .cmd_stall_i (fifo_stall)
  );

  // Buffer nibble commands
  adpcm4_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_cmd_i   (front_cmd),
    .wr_valid_i (front_valid),
    .wr_stall_o (fifo_stall),
    .rd_cmd_o   (back_cmd),
    .rd_valid_o (back_valid),
    .rd_pop_i   (back_pop)
  );

  // Decode nibbles
  adpcm4_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (back_cmd),
    .cmd_valid_i (back_valid),
    .cmd_pop_o   (back_pop),
    .out_item_o  (out_item_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the leaky 4-bit ADPCM decoder. A short table of
// directed code bytes comes first, then random streams of bytes. A behavioral
// decoder in the bench predicts both samples of every byte, and each output
// word is compared field by field against the oldest prediction. Both
// channels idle at random, the receiver holds off once for a long stretch,
// and the sender once waits until every sample has drained.
// ----------------------------------------------------------------------------
module tb_top;
  import adpcm4_pkg::*;

  localparam int CycleLimit  = 600000;
  localparam int RandomWords = 1300;
  localparam int TailCycles  = 64;
  localparam int LongHold    = 300;
  localparam int HoldAtWord  = 500;
  localparam int DrainAtWord = 700;
  localparam int MaxWait     = 17;
  localparam int DirRows     = 24;

  // How often a side idles before its next word
  typedef enum int {
    PaceFree,
    PaceRandom,
    PaceSparse
  } pace_e;

  // Directed row: byte, flags, and samples typed in where they are obvious
  typedef struct packed {
    logic [7:0]         code;
    logic               start;
    logic               stop;
    logic               typed;
    logic signed [15:0] lo;
    logic signed [15:0] hi;
  } dir_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  in_item_t  in_item = '0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  out_item_t out_item;
  logic      out_valid;
  logic      out_stall = 1'b0;

  // Behavioral decoder state
  int pred_sample;
  int pred_step;

  out_item_t pcm_expected_q[$];
  out_item_t want_word;
  int        errors = 0;
  int        words_seen = 0;
  int        cycle_count = 0;
  bit        long_hold_done = 1'b0;
  dir_row_t  dir_rows [DirRows];

  adpcm_4bit_decoder_leaky_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .out_item_o (out_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall)
  );

  always #5 clk_i = ~clk_i;

  // Draw the idle cycles before the next word for a given pace
  function automatic int draw_wait(input pace_e pace);
    case (pace)
      PaceFree:   return 0;
      PaceRandom: return $urandom_range(0, MaxWait);
      default:    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MaxWait) : 0;
    endcase
  endfunction

  // Decode one nibble: scaled step difference, saturate, adapt step, decay
  function automatic out_item_t decode_code(input logic [3:0] code, input logic second,
                                            input logic last);
    int        mag;
    int        delta;
    int        total;
    int        factor;
    int        scaled;
    out_item_t r;
    mag   = 2 * int'(code[2:0]) + 1;
    delta = pred_step * mag;
    if (code[3]) begin
      delta = -delta;
    end
    delta = delta / 8;
    total = pred_sample + delta;
    if (total > int'(SampleMax)) begin
      total = int'(SampleMax);
    end
    if (total < int'(SampleMin)) begin
      total = int'(SampleMin);
    end
    case (code[2:0])
      3'd4:    factor = 'h133;
      3'd5:    factor = 'h199;
      3'd6:    factor = 'h200;
      3'd7:    factor = 'h266;
      default: factor = 'h0e6;
    endcase
    scaled = (pred_step * factor) >>> 8;
    if (scaled < int'(StepMin)) begin
      scaled = int'(StepMin);
    end
    if (scaled > int'(StepMax)) begin
      scaled = int'(StepMax);
    end
    pred_step   = scaled;
    pred_sample = (total * 254) / 256;
    r.pcm_sample     = 16'(total);
    r.second_of_byte = second;
    r.end_of_stream  = last;
    return r;
  endfunction

  // Predict both samples of a byte, then offer it until accepted
  task automatic send_word(input in_item_t w, input logic typed,
                           input logic signed [15:0] lo_val,
                           input logic signed [15:0] hi_val, input pace_e pace);
    out_item_t lo;
    out_item_t hi;
    int        gap;
    if (w.stream_start) begin
      pred_sample = 0;
      pred_step   = int'(StepMin);
    end
    lo = decode_code(w.code_byte[3:0], 1'b0, 1'b0);
    hi = decode_code(w.code_byte[7:4], 1'b1, w.stream_end);
    if (typed) begin
      lo.pcm_sample = lo_val;
      hi.pcm_sample = hi_val;
    end
    pcm_expected_q.push_back(lo);
    pcm_expected_q.push_back(hi);
    gap = draw_wait(pace);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_item  <= w;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
  endtask

  // Stimulus: directed table, then random streams
  initial begin : sender
    in_item_t w;
    pace_e    pace;
    int       sent;
    int       len;
    int       style;
    bit       sgn;
    bit       drained;
    pred_sample = 0;
    pred_step   = int'(StepMin);
    sent    = 0;
    drained = 1'b0;
    pace    = PaceRandom;
    dir_rows = '{
      // fresh stream, smallest codes: step 0x7f gives +15 per nibble
      '{8'h00, 1'b1, 1'b0, 1'b1, 16'sd15, 16'sd29},
      // negative codes round toward zero
      '{8'h88, 1'b1, 1'b0, 1'b1, -16'sd15, -16'sd29},
      // start and end on one byte
      '{8'h00, 1'b1, 1'b1, 1'b1, 16'sd15, 16'sd29},
      // largest positive codes until the sample saturates high
      '{8'h76, 1'b1, 1'b0, 1'b0, 16'sd0, 16'sd0},
      '{8'h77, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0},
      '{8'h77, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0},
      '{8'h77, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0},
      '{8'h77, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0},
      // largest negative codes until the sample saturates low
      '{8'hff, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0},
      '{8'hff, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0},
      '{8'hff, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0},
      '{8'hff, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0},
      // small codes shrink the step back toward its floor
      '{8'h00, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0},
      '{8'h00, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0},
      // codes 0-5 and 8-15, even ones in the low nibble, odd in the high
      '{8'h54, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0},
      '{8'h32, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0},
      '{8'h10, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0},
      '{8'hba, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0},
      '{8'hdc, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0},
      '{8'hfe, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0},
      '{8'h98, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0},
      // end of stream, then a byte that continues without a start
      '{8'ha5, 1'b0, 1'b1, 1'b0, 16'sd0, 16'sd0},
      '{8'h3c, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0},
      '{8'hc3, 1'b1, 1'b1, 1'b0, 16'sd0, 16'sd0}
    };

    // Hold reset, then release it on a falling edge
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      w.code_byte    = dir_rows[i].code;
      w.stream_start = dir_rows[i].start;
      w.stream_end   = dir_rows[i].stop;
      send_word(w, dir_rows[i].typed, dir_rows[i].lo, dir_rows[i].hi, pace);
    end

    while (sent < RandomWords) begin
      // Pause once until every sample has drained
      if (!drained && sent >= DrainAtWord) begin
        in_valid <= 1'b0;
        do @(negedge clk_i); while (pcm_expected_q.size() != 0);
        drained = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) begin
        // Noise: any byte with any flags
        w.code_byte    = 8'($urandom_range(0, 255));
        w.stream_start = 1'($urandom_range(0, 1));
        w.stream_end   = 1'($urandom_range(0, 1));
        send_word(w, 1'b0, 16'sd0, 16'sd0, pace);
        sent++;
      end else begin
        // Well-formed stream: start on the first byte, end on the last
        len   = $urandom_range(1, 40);
        style = $urandom_range(0, 3);
        sgn   = 1'($urandom_range(0, 1));
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 24) == 0) begin
            pace = pace_e'($urandom_range(0, 2));
          end
          case (style)
            2: begin
              // loud: large magnitudes of one sign to reach saturation
              w.code_byte[7]   = sgn;
              w.code_byte[6:4] = 3'($urandom_range(5, 7));
              w.code_byte[3]   = sgn;
              w.code_byte[2:0] = 3'($urandom_range(5, 7));
            end
            3: begin
              // quiet: smallest magnitudes, step sits near its floor
              w.code_byte[7:4] = {1'($urandom_range(0, 1)), 2'b00, 1'($urandom_range(0, 1))};
              w.code_byte[3:0] = {1'($urandom_range(0, 1)), 2'b00, 1'($urandom_range(0, 1))};
            end
            default: w.code_byte = 8'($urandom_range(0, 255));
          endcase
          w.stream_start = (k == 0);
          w.stream_end   = (k == len - 1);
          send_word(w, 1'b0, 16'sd0, 16'sd0, pace);
          sent++;
        end
      end
    end
    in_valid <= 1'b0;

    // Drain, then let the pipeline settle
    while (pcm_expected_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (errors == 0 && pcm_expected_q.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Receiver: stall at random, and once for a long stretch
  initial begin : receiver
    int    hold;
    pace_e pace;
    pace = PaceRandom;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) begin
        pace = pace_e'($urandom_range(0, 2));
      end
      hold = draw_wait(pace);
      if (!long_hold_done && words_seen >= HoldAtWord) begin
        hold = LongHold;
        long_hold_done = 1'b1;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid);
      @(negedge clk_i);
    end
  end

  // Check each accepted sample against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      words_seen++;
      if (pcm_expected_q.size() == 0) begin
        errors++;
        $display("%0t: sample with none expected: got %p", $time, out_item);
      end else begin
        want_word = pcm_expected_q.pop_front();
        if (out_item.pcm_sample !== want_word.pcm_sample) begin
          errors++;
          $display("%0t: pcm_sample expected %0d got %0d", $time,
                   want_word.pcm_sample, out_item.pcm_sample);
        end
        if (out_item.second_of_byte !== want_word.second_of_byte) begin
          errors++;
          $display("%0t: second_of_byte expected %b got %b", $time,
                   want_word.second_of_byte, out_item.second_of_byte);
        end
        if (out_item.end_of_stream !== want_word.end_of_stream) begin
          errors++;
          $display("%0t: end_of_stream expected %b got %b", $time,
                   want_word.end_of_stream, out_item.end_of_stream);
        end
      end
    end
  end

  // Abort a run that hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

endmodule
